FILE: rtl/core/gns_pkg.sv
// Package for the grid neighbour search unit: constants, op codes, record layouts,
// controller/datapath command and status structures and the grid cell function.
// Depends on nothing; every other file but gns_ram refers to it, by scoped names or by import.
package gns_pkg;

   localparam int MAX_POINTS     = 1024;
   localparam int GRID_W         = 64;
   localparam int GRID_H         = 64;
   localparam int MAX_NEIGHBOURS = 32;

   localparam int POS_W   = 20;
   localparam int FRAC_W  = 16;
   localparam int DSQ_W   = 41;
   localparam int DIST_W  = 21;
   localparam int NB_W    = 6;
   localparam int IDX_W   = $clog2(MAX_POINTS);
   localparam int CNT_W   = $clog2(MAX_POINTS + 1);
   localparam int CX_W    = $clog2(GRID_W);
   localparam int CY_W    = $clog2(GRID_H);
   localparam int N_CELLS = GRID_W * GRID_H;
   localparam int CELL_W  = $clog2(N_CELLS);
   localparam int GRID_MAX = (GRID_W > GRID_H) ? GRID_W : GRID_H;
   localparam int COORD_W = $clog2(GRID_MAX + 1);
   localparam int CSR_IDX_W = 1;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST_SQ = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST_SQ = 1'd1;

   localparam logic [DSQ_W-1:0] MIN_DIST_SQ_RESET = 41'd1;
   localparam logic [DSQ_W-1:0] MAX_DIST_SQ_RESET = 41'd1048576;

   // Offsets 0..2 around the centre cell; the last one ends a row of the walk.
   localparam logic [1:0] WALK_LAST = 2'd2;

   typedef struct packed {
      logic                    link_valid;
      logic [IDX_W-1:0]        link_idx;
      logic [CY_W-1:0]         cy;
      logic [CX_W-1:0]         cx;
      logic signed [POS_W-1:0] y;
      logic signed [POS_W-1:0] x;
   } gns_rec_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } gns_head_type;

   typedef struct packed {
      logic clr_init;
      logic clr_step;
      logic capture;
      logic ld_write;
      logic rec_rd_query;
      logic rec_rd_head;
      logic head_rd_walk;
      logic q_capture;
      logic head_take;
      logic cell_next;
      logic pt_capture;
      logic sum;
      logic sqrt_start;
      logic emit;
      logic link_take;
      logic flush;
   } gns_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic full;
      logic q_ok;
      logic head_valid;
      logic link_valid;
      logic last_cell;
      logic in_range;
      logic sqrt_busy;
      logic pend_valid;
      logic out_free;
      logic count_full;
   } gns_status_type;

   // Grid coordinate of one axis: floor(p * size) in Q.16, clamped to 1..size-2.
   function automatic logic [COORD_W-1:0] cell_coord(input logic signed [POS_W-1:0] p,
                                                     input int unsigned size);
      logic [POS_W+COORD_W-1:0] prod;
      logic [POS_W+COORD_W-1:0] c;
      prod = (POS_W+COORD_W)'(unsigned'(p)) * (POS_W+COORD_W)'(size);
      c    = prod >> FRAC_W;
      if (p <= 0) begin
         c = (POS_W+COORD_W)'(1);
      end else if (c < (POS_W+COORD_W)'(1)) begin
         c = (POS_W+COORD_W)'(1);
      end else if (c > (POS_W+COORD_W)'(size - 2)) begin
         c = (POS_W+COORD_W)'(size - 2);
      end
      return c[COORD_W-1:0];
   endfunction

endpackage

FILE: rtl/core/gns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/gns_sqrt.sv
// Bit-serial integer square root, rounded down, one result bit per cycle.
// Depends on gns_pkg.
module gns_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gns_pkg::DSQ_W-1:0]   value,
   output logic                        busy,
   output logic [gns_pkg::DIST_W-1:0]  root
);

   localparam int RAD_W = 2 * gns_pkg::DIST_W;
   localparam int REM_W = gns_pkg::DIST_W + 2;
   localparam int ITW   = $clog2(gns_pkg::DIST_W + 1);

   logic [RAD_W-1:0]          rad_ff;
   logic [REM_W-1:0]          rem_ff;
   logic [gns_pkg::DIST_W-1:0] root_ff;
   logic [ITW-1:0]            iter_ff;
   logic                      busy_ff;

   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   logic             take;

   assign rem_sh = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial  = {1'b0, 1'b0, root_ff, 2'b01};
   assign take   = (rem_sh >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         iter_ff <= ITW'(gns_pkg::DIST_W);
      end else if (busy_ff) begin
         iter_ff <= iter_ff - ITW'(1);
         if (iter_ff == ITW'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= RAD_W'(value);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (take) begin
            rem_ff  <= REM_W'(rem_sh - trial);
            root_ff <= {root_ff[gns_pkg::DIST_W-2:0], 1'b1};
         end else begin
            rem_ff  <= REM_W'(rem_sh);
            root_ff <= {root_ff[gns_pkg::DIST_W-2:0], 1'b0};
         end
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

FILE: rtl/core/gns_datapath.sv
// Datapath of the grid neighbour search: point and cell-head memories, walk
// registers, distance arithmetic, result buffering and configuration registers.
// Depends on gns_pkg, gns_ram and gns_sqrt.
module gns_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  gns_pkg::gns_cmd_type                 cmd,
   output gns_pkg::gns_status_type              st,
   input  logic signed [gns_pkg::POS_W-1:0]     req_pos_x,
   input  logic signed [gns_pkg::POS_W-1:0]     req_pos_y,
   input  logic [gns_pkg::IDX_W-1:0]            req_query_index,
   input  logic                                 csr_wr_en,
   input  logic [gns_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [gns_pkg::DSQ_W-1:0]            csr_wr_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [gns_pkg::IDX_W-1:0]            rsp_neighbour_index,
   output logic [gns_pkg::DIST_W-1:0]           rsp_distance,
   output logic                                 rsp_has_neighbour,
   output logic [gns_pkg::NB_W-1:0]             rsp_nb_total,
   output logic                                 rsp_last
);

   localparam int CX_W   = gns_pkg::CX_W;
   localparam int CY_W   = gns_pkg::CY_W;
   localparam int CELL_W = gns_pkg::CELL_W;
   localparam int IDX_W  = gns_pkg::IDX_W;
   localparam int CNT_W  = gns_pkg::CNT_W;
   localparam int POS_W  = gns_pkg::POS_W;
   localparam int DSQ_W  = gns_pkg::DSQ_W;
   localparam int DIST_W = gns_pkg::DIST_W;
   localparam int NB_W   = gns_pkg::NB_W;

   // Configuration.
   logic [DSQ_W-1:0] min_dsq_ff;
   logic [DSQ_W-1:0] max_dsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dsq_ff <= gns_pkg::MIN_DIST_SQ_RESET;
         max_dsq_ff <= gns_pkg::MAX_DIST_SQ_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gns_pkg::CSR_MIN_DIST_SQ: min_dsq_ff <= csr_wr_data;
            gns_pkg::CSR_MAX_DIST_SQ: max_dsq_ff <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Captured request.
   logic signed [POS_W-1:0] ld_x_ff;
   logic signed [POS_W-1:0] ld_y_ff;
   logic [CX_W-1:0]         ld_cx_ff;
   logic [CY_W-1:0]         ld_cy_ff;
   logic [IDX_W-1:0]        q_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ld_x_ff  <= req_pos_x;
         ld_y_ff  <= req_pos_y;
         ld_cx_ff <= CX_W'(gns_pkg::cell_coord(req_pos_x, gns_pkg::GRID_W));
         ld_cy_ff <= CY_W'(gns_pkg::cell_coord(req_pos_y, gns_pkg::GRID_H));
         q_ff     <= req_query_index;
      end
   end

   // Fill count and clearing sweep.
   logic [CNT_W-1:0]  stored_ff;
   logic [CELL_W-1:0] clr_ptr_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clr_init) begin
         stored_ff  <= '0;
         clr_ptr_ff <= '0;
      end else begin
         if (cmd.clr_step) begin
            clr_ptr_ff <= clr_ptr_ff + CELL_W'(1);
         end
         if (cmd.ld_write) begin
            stored_ff <= stored_ff + CNT_W'(1);
         end
      end
   end

   // Query point and walk position.
   logic signed [POS_W-1:0] qx_ff;
   logic signed [POS_W-1:0] qy_ff;
   logic [CX_W-1:0]         qcx_ff;
   logic [CY_W-1:0]         qcy_ff;
   logic [1:0]              dxc_ff;
   logic [1:0]              dyc_ff;
   logic [IDX_W-1:0]        j_ff;
   logic                    link_valid_ff;
   logic [IDX_W-1:0]        link_idx_ff;

   gns_pkg::gns_rec_type  rec_rdata;
   gns_pkg::gns_rec_type  rec_wdata;
   gns_pkg::gns_head_type head_rdata;
   gns_pkg::gns_head_type head_wdata;
   logic [IDX_W-1:0]      rec_raddr;
   logic [CELL_W-1:0]     head_raddr;
   logic [CELL_W-1:0]     head_waddr;
   logic [CELL_W-1:0]     ld_cell;
   logic [CELL_W-1:0]     walk_cell;
   logic [CX_W-1:0]       walk_cx;
   logic [CY_W-1:0]       walk_cy;

   assign ld_cell   = CELL_W'(CELL_W'(ld_cy_ff) * CELL_W'(gns_pkg::GRID_W)) + CELL_W'(ld_cx_ff);
   assign walk_cx   = qcx_ff + CX_W'(dxc_ff) - CX_W'(1);
   assign walk_cy   = qcy_ff + CY_W'(dyc_ff) - CY_W'(1);
   assign walk_cell = CELL_W'(CELL_W'(walk_cy) * CELL_W'(gns_pkg::GRID_W)) + CELL_W'(walk_cx);

   assign head_raddr = cmd.head_rd_walk ? walk_cell : ld_cell;
   assign head_waddr = cmd.clr_step ? clr_ptr_ff : ld_cell;
   assign head_wdata = cmd.clr_step ? gns_pkg::gns_head_type'('0) :
                       gns_pkg::gns_head_type'{valid: 1'b1, idx: stored_ff[IDX_W-1:0]};

   assign rec_raddr = cmd.rec_rd_query ? q_ff :
                      cmd.rec_rd_head  ? head_rdata.idx : link_idx_ff;

   assign rec_wdata = '{link_valid: head_rdata.valid, link_idx: head_rdata.idx,
                        cy: ld_cy_ff, cx: ld_cx_ff, y: ld_y_ff, x: ld_x_ff};

   gns_ram #(
      .WIDTH ($bits(gns_pkg::gns_head_type)),
      .DEPTH (gns_pkg::N_CELLS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (cmd.clr_step || cmd.ld_write),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   gns_ram #(
      .WIDTH ($bits(gns_pkg::gns_rec_type)),
      .DEPTH (gns_pkg::MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (cmd.ld_write),
      .wr_addr (stored_ff[IDX_W-1:0]),
      .wr_data (rec_wdata),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.q_capture) begin
         qx_ff  <= rec_rdata.x;
         qy_ff  <= rec_rdata.y;
         qcx_ff <= rec_rdata.cx;
         qcy_ff <= rec_rdata.cy;
         dxc_ff <= '0;
         dyc_ff <= '0;
      end else if (cmd.cell_next) begin
         if (dyc_ff == gns_pkg::WALK_LAST) begin
            dyc_ff <= '0;
            dxc_ff <= dxc_ff + 2'd1;
         end else begin
            dyc_ff <= dyc_ff + 2'd1;
         end
      end
      if (cmd.head_take) begin
         j_ff <= head_rdata.idx;
      end else if (cmd.link_take) begin
         j_ff <= link_idx_ff;
      end
   end

   // Distance arithmetic: squares, sum, window compare, root.
   logic signed [POS_W:0]     dx;
   logic signed [POS_W:0]     dy;
   logic signed [2*POS_W+1:0] sqx;
   logic signed [2*POS_W+1:0] sqy;
   logic [DSQ_W-1:0]          sqx_ff;
   logic [DSQ_W-1:0]          sqy_ff;
   logic [DSQ_W-1:0]          r2_ff;
   logic [DIST_W-1:0]         root;
   logic                      sqrt_busy;

   assign dx  = (POS_W+1)'(qx_ff) - (POS_W+1)'(rec_rdata.x);
   assign dy  = (POS_W+1)'(qy_ff) - (POS_W+1)'(rec_rdata.y);
   assign sqx = dx * dx;
   assign sqy = dy * dy;

   always_ff @(posedge clock) begin
      if (cmd.pt_capture) begin
         sqx_ff        <= sqx[DSQ_W-1:0];
         sqy_ff        <= sqy[DSQ_W-1:0];
         link_valid_ff <= rec_rdata.link_valid;
         link_idx_ff   <= rec_rdata.link_idx;
      end
      if (cmd.sum) begin
         r2_ff <= sqx_ff + sqy_ff;
      end
   end

   gns_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value (r2_ff),
      .busy  (sqrt_busy),
      .root  (root)
   );

   // Result buffering: one found result is held back until the next one or the
   // end of the walk decides whether it is the last.
   logic [NB_W-1:0]   n_ff;
   logic              pend_valid_ff;
   logic [IDX_W-1:0]  pend_idx_ff;
   logic [DIST_W-1:0] pend_dist_ff;
   logic [NB_W-1:0]   pend_count_ff;
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  rsp_idx_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_has_ff;
   logic [NB_W-1:0]   rsp_count_ff;
   logic              rsp_last_ff;
   logic              out_free;
   logic              out_load;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (cmd.emit && pend_valid_ff) || cmd.flush;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.q_capture) begin
            n_ff <= '0;
         end else if (cmd.emit) begin
            n_ff <= n_ff + NB_W'(1);
         end
         if (cmd.emit) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pend_idx_ff   <= j_ff;
         pend_dist_ff  <= root;
         pend_count_ff <= n_ff + NB_W'(1);
      end
      if (out_load) begin
         if (pend_valid_ff) begin
            rsp_idx_ff   <= pend_idx_ff;
            rsp_dist_ff  <= pend_dist_ff;
            rsp_has_ff   <= 1'b1;
            rsp_count_ff <= pend_count_ff;
         end else begin
            rsp_idx_ff   <= '0;
            rsp_dist_ff  <= '0;
            rsp_has_ff   <= 1'b0;
            rsp_count_ff <= '0;
         end
         rsp_last_ff <= cmd.flush;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_neighbour_index = rsp_idx_ff;
   assign rsp_distance        = rsp_dist_ff;
   assign rsp_has_neighbour   = rsp_has_ff;
   assign rsp_nb_total        = rsp_count_ff;
   assign rsp_last            = rsp_last_ff;

   // Status back to the controller.
   assign st.clr_last   = (clr_ptr_ff == CELL_W'(gns_pkg::N_CELLS - 1));
   assign st.full       = (stored_ff >= CNT_W'(gns_pkg::MAX_POINTS));
   assign st.q_ok       = (CNT_W'(q_ff) < stored_ff);
   assign st.head_valid = head_rdata.valid;
   assign st.link_valid = link_valid_ff;
   assign st.last_cell  = (dxc_ff == gns_pkg::WALK_LAST) && (dyc_ff == gns_pkg::WALK_LAST);
   assign st.in_range   = (r2_ff >= min_dsq_ff) && (r2_ff <= max_dsq_ff);
   assign st.sqrt_busy  = sqrt_busy;
   assign st.pend_valid = pend_valid_ff;
   assign st.out_free   = out_free;
   assign st.count_full = (n_ff == NB_W'(gns_pkg::MAX_NEIGHBOURS));

endmodule

FILE: rtl/core/gns_ctrl.sv
// Controller state machine of the grid neighbour search: clearing sweep, load,
// query walk over the nine cells and result hand-off. Depends on gns_pkg.
module gns_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_op,
   output logic                    req_stall,
   output gns_pkg::gns_cmd_type    cmd,
   input  gns_pkg::gns_status_type st
);

   typedef enum logic [14:0] {
      ST_CLEAR    = 15'b000000000000001,
      ST_IDLE     = 15'b000000000000010,
      ST_LD_RD    = 15'b000000000000100,
      ST_LD_WR    = 15'b000000000001000,
      ST_Q_RD     = 15'b000000000010000,
      ST_Q_LAT    = 15'b000000000100000,
      ST_CELL_RD  = 15'b000000001000000,
      ST_CELL_LAT = 15'b000000010000000,
      ST_PT_LAT   = 15'b000000100000000,
      ST_PT_SUM   = 15'b000001000000000,
      ST_PT_CMP   = 15'b000010000000000,
      ST_SQRT     = 15'b000100000000000,
      ST_EMIT     = 15'b001000000000000,
      ST_NEXT     = 15'b010000000000000,
      ST_FLUSH    = 15'b100000000000000
   } gns_state_type;

   gns_state_type state_ff;
   gns_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  gns_pkg::OP_CLEAR: begin
                     cmd.clr_init = 1'b1;
                     state_in     = ST_CLEAR;
                  end
                  gns_pkg::OP_LOAD: begin
                     if (!st.full) begin
                        cmd.capture = 1'b1;
                        state_in    = ST_LD_RD;
                     end
                  end
                  gns_pkg::OP_QUERY: begin
                     cmd.capture = 1'b1;
                     state_in    = ST_Q_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_LD_RD: begin
            state_in = ST_LD_WR;
         end
         ST_LD_WR: begin
            cmd.ld_write = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_Q_RD: begin
            cmd.rec_rd_query = 1'b1;
            state_in         = ST_Q_LAT;
         end
         ST_Q_LAT: begin
            cmd.q_capture = 1'b1;
            state_in      = st.q_ok ? ST_CELL_RD : ST_FLUSH;
         end
         ST_CELL_RD: begin
            cmd.head_rd_walk = 1'b1;
            state_in         = ST_CELL_LAT;
         end
         ST_CELL_LAT: begin
            if (st.head_valid) begin
               cmd.rec_rd_head = 1'b1;
               cmd.head_take   = 1'b1;
               state_in        = ST_PT_LAT;
            end else if (st.last_cell) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.cell_next = 1'b1;
               state_in      = ST_CELL_RD;
            end
         end
         ST_PT_LAT: begin
            cmd.pt_capture = 1'b1;
            state_in       = ST_PT_SUM;
         end
         ST_PT_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_PT_CMP;
         end
         ST_PT_CMP: begin
            if (st.in_range) begin
               cmd.sqrt_start = 1'b1;
               state_in       = ST_SQRT;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_SQRT: begin
            if (!st.sqrt_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!st.pend_valid || st.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (st.count_full) begin
               state_in = ST_FLUSH;
            end else if (st.link_valid) begin
               cmd.link_take = 1'b1;
               state_in      = ST_PT_LAT;
            end else if (st.last_cell) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.cell_next = 1'b1;
               state_in      = ST_CELL_RD;
            end
         end
         ST_FLUSH: begin
            if (st.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // No result may be held back once the block is ready for a new word.
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !st.pend_valid)
      else $error("held result left behind at end of query");

   a_sqrt_free: assert property (@(posedge clock) disable iff (reset)
      cmd.sqrt_start |-> !st.sqrt_busy)
      else $error("square root restarted while busy");

   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && st.pend_valid) |-> st.out_free)
      else $error("result pushed into occupied output register");

   a_flush_room: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> !st.pend_valid)
      else $error("held result survived the final hand-off");

endmodule

FILE: rtl/core/grid_neighbour_search_unit.sv
// Top level of the grid neighbour search unit: controller and datapath.
// Depends on gns_pkg, gns_ctrl and gns_datapath.
//
// Usage. Request words arrive on req_* (valid/stall); result words leave on
// rsp_* (valid/stall). A clear word empties every cell list and the point
// count, a load word stores one point at the next free index and pushes it onto
// its grid cell's list, a query word walks the 3x3 cells around a stored point.
// Clear and load give no result word; a query gives one word per neighbour
// found (last set on the final one) or a single empty word with last set.
// The distance window is written on csr_* while the block is idle.
//
// Timing. A load reads its cell head, then writes the point and new head. A
// clear sweeps every cell head, one per cycle through the head memory's single
// write port. A query reads the queried record, then each visited cell's head
// and each listed point's record, which it squares, sums and compares; each
// accepted neighbour passes the bit-serial square root (one bit per cycle, 21
// bits). The block takes one word at a time; req_stall is low only when idle.
//
// Reset runs the same clearing pass over the cell heads, with req_stall high. The
// result register holds its word while rsp_stall is high; one further found
// result is kept back inside and the walk waits for room.
module grid_neighbour_search_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic signed [gns_pkg::POS_W-1:0]    req_pos_x,
   input  logic signed [gns_pkg::POS_W-1:0]    req_pos_y,
   input  logic [gns_pkg::IDX_W-1:0]           req_query_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gns_pkg::IDX_W-1:0]           rsp_neighbour_index,
   output logic [gns_pkg::DIST_W-1:0]          rsp_distance,
   output logic                                rsp_has_neighbour,
   output logic [gns_pkg::NB_W-1:0]            rsp_nb_total,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [gns_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gns_pkg::DSQ_W-1:0]           csr_wr_data
);

   gns_pkg::gns_cmd_type    cmd;
   gns_pkg::gns_status_type st;

   // The controller sequences every operation; the datapath acts on its commands,
   // takes register writes on csr_* directly and reports status back.
   gns_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .cmd       (cmd),
      .st        (st)
   );

   gns_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_query_index     (req_query_index),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_neighbour_index (rsp_neighbour_index),
      .rsp_distance        (rsp_distance),
      .rsp_has_neighbour   (rsp_has_neighbour),
      .rsp_nb_total        (rsp_nb_total),
      .rsp_last            (rsp_last)
   );

endmodule

FILE: tb/gns_checker.sv
// Checker for the grid neighbour search unit: snoops the request, result and register ports,
// keeps its own copy of the point store and cell lists, and compares every result word.
// Depends on gns_pkg for widths and op codes.
`timescale 1ns / 100ps

module gns_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic signed [gns_pkg::POS_W-1:0]  req_pos_x,
   input  logic signed [gns_pkg::POS_W-1:0]  req_pos_y,
   input  logic [gns_pkg::IDX_W-1:0]         req_query_index,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [gns_pkg::IDX_W-1:0]         rsp_neighbour_index,
   input  logic [gns_pkg::DIST_W-1:0]        rsp_distance,
   input  logic                              rsp_has_neighbour,
   input  logic [gns_pkg::NB_W-1:0]          rsp_nb_total,
   input  logic                              rsp_last,
   input  logic                              csr_wr_en,
   input  logic [gns_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gns_pkg::DSQ_W-1:0]         csr_wr_data,
   output int                                fail_count,
   output int                                pending,
   output int                                words_checked
);
   import gns_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [DIST_W-1:0] span;
      logic              has;
      logic [NB_W-1:0]   cnt;
      logic              last;
   } hit_type;

   hit_type                 hits_due[$];
   logic [DSQ_W-1:0]        lo_sq, hi_sq;
   int                      n_stored;
   logic signed [POS_W-1:0] px [MAX_POINTS];
   logic signed [POS_W-1:0] py [MAX_POINTS];
   int                      pcell [MAX_POINTS];
   int                      plink [MAX_POINTS];
   logic                    plink_ok [MAX_POINTS];
   int                      head [N_CELLS];
   logic                    head_ok [N_CELLS];

   assign pending = hits_due.size();

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic int grid_axis(input logic signed [POS_W-1:0] p, input int size);
      longint c;
      if (p <= 0) return 1;
      c = (longint'(p) * size) >>> FRAC_W;
      if (c < 1) c = 1;
      if (c > size - 2) c = size - 2;
      return int'(c);
   endfunction

   function automatic logic [DIST_W-1:0] root_floor(input longint unsigned v);
      longint unsigned r, t;
      r = 0;
      for (int b = DIST_W - 1; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= v) r = t;
      end
      return r[DIST_W-1:0];
   endfunction

   // Walks the 3x3 cells around the queried point and queues the words it should produce.
   task automatic predict_query(input int q);
      int               n, cx, cy, cell_no, j, steps;
      logic             ok;
      longint           dx, dy;
      longint unsigned  r2;
      hit_type          h;
      n = 0;
      if (q < n_stored) begin
         cx = pcell[q] % GRID_W;
         cy = pcell[q] / GRID_W;
         for (int ox = 0; ox < 3 && n < MAX_NEIGHBOURS; ox++) begin
            for (int oy = 0; oy < 3 && n < MAX_NEIGHBOURS; oy++) begin
               cell_no = (cx + ox - 1) + (cy + oy - 1) * GRID_W;
               if (cell_no < 0 || cell_no >= N_CELLS) continue;
               ok = head_ok[cell_no];
               j = head[cell_no];
               steps = 0;
               while (ok && steps < MAX_POINTS && n < MAX_NEIGHBOURS) begin
                  dx = longint'(px[q]) - longint'(px[j]);
                  dy = longint'(py[q]) - longint'(py[j]);
                  r2 = longint'(dx * dx + dy * dy);
                  if (r2 >= lo_sq && r2 <= hi_sq) begin
                     n++;
                     h.idx = j[IDX_W-1:0];
                     h.span = root_floor(r2);
                     h.has = 1'b1;
                     h.cnt = n[NB_W-1:0];
                     h.last = 1'b0;
                     hits_due.push_back(h);
                  end
                  ok = plink_ok[j];
                  j = plink[j];
                  steps++;
               end
            end
         end
      end
      if (n == 0) begin
         h = '0;
         h.last = 1'b1;
         hits_due.push_back(h);
      end else begin
         hits_due[hits_due.size() - 1].last = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      hit_type want;
      int      i, cell_no;
      if (reset) begin
         lo_sq = MIN_DIST_SQ_RESET;
         hi_sq = MAX_DIST_SQ_RESET;
         n_stored = 0;
         fail_count = 0;
         words_checked = 0;
         for (int c = 0; c < N_CELLS; c++) head_ok[c] = 1'b0;
      end else begin
         // Result side first: a word leaving now can only belong to an earlier query.
         if (rsp_valid && !rsp_stall) begin
            words_checked++;
            if (hits_due.size() == 0) begin
               report("result word with nothing expected, words", 1, 0);
            end else begin
               want = hits_due.pop_front();
               if (rsp_neighbour_index !== want.idx)
                  report("neighbour_index", rsp_neighbour_index, want.idx);
               if (rsp_distance !== want.span) report("distance", rsp_distance, want.span);
               if (rsp_has_neighbour !== want.has)
                  report("has_neighbour", rsp_has_neighbour, want.has);
               if (rsp_nb_total !== want.cnt)
                  report("nb_total", rsp_nb_total, want.cnt);
               if (rsp_last !== want.last) report("last", rsp_last, want.last);
            end
         end
         if (csr_wr_en) begin
            if (csr_index == CSR_MIN_DIST_SQ) lo_sq = csr_wr_data;
            else if (csr_index == CSR_MAX_DIST_SQ) hi_sq = csr_wr_data;
         end
         if (req_valid && !req_stall) begin
            case (req_op)
               OP_CLEAR: begin
                  for (int c = 0; c < N_CELLS; c++) head_ok[c] = 1'b0;
                  n_stored = 0;
               end
               OP_LOAD: begin
                  if (n_stored < MAX_POINTS) begin
                     i = n_stored;
                     cell_no = grid_axis(req_pos_x, GRID_W) +
                               grid_axis(req_pos_y, GRID_H) * GRID_W;
                     px[i] = req_pos_x;
                     py[i] = req_pos_y;
                     pcell[i] = cell_no;
                     plink[i] = head[cell_no];
                     plink_ok[i] = head_ok[cell_no];
                     head[cell_no] = i;
                     head_ok[cell_no] = 1'b1;
                     n_stored = i + 1;
                  end
               end
               OP_QUERY: predict_query(int'(req_query_index));
               default: ;
            endcase
         end
      end
   end
endmodule

FILE: tb/tb.sv
// Top of the grid neighbour search testbench: clock, reset, request and register stimulus,
// random result back-pressure and the verdict.
// Depends on gns_pkg, gns_checker and grid_neighbour_search_unit.
`timescale 1ns / 100ps

module tb;
   import gns_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   // A clear runs one cell head per cycle, so the block may still be busy for this long
   // after the last result word has gone.
   localparam int SETTLE = N_CELLS + 200;
   localparam logic signed [POS_W-1:0] POS_HI = 20'sh7FFFF;
   localparam logic signed [POS_W-1:0] POS_LO = -20'sh80000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_op = OP_CLEAR;
   logic signed [POS_W-1:0] req_pos_x = '0;
   logic signed [POS_W-1:0] req_pos_y = '0;
   logic [IDX_W-1:0]        req_query_index = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b1;
   logic [IDX_W-1:0]        rsp_neighbour_index;
   logic [DIST_W-1:0]       rsp_distance;
   logic                    rsp_has_neighbour;
   logic [NB_W-1:0]         rsp_nb_total;
   logic                    rsp_last;
   logic                    csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = CSR_MIN_DIST_SQ;
   logic [DSQ_W-1:0]        csr_wr_data = '0;

   int fail_count, pending, words_checked;
   int words_sent = 0;
   // While calm is set neither side idles, giving back-to-back stretches.
   bit calm = 1'b0;

   always #5 clock = ~clock;

   grid_neighbour_search_unit dut (.*);

   gns_checker chk (.*);

   // One request word: an idle gap, then valid held until the block takes it.
   task automatic send_word(input logic [1:0] op, input logic signed [POS_W-1:0] x,
                            input logic signed [POS_W-1:0] y, input int q);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      repeat (gap) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_op = op;
      req_pos_x = x;
      req_pos_y = y;
      req_query_index = q[IDX_W-1:0];
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   task automatic load_point(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y);
      send_word(OP_LOAD, x, y, $urandom_range(0, 1023));
   endtask

   task automatic query_point(input int q);
      send_word(OP_QUERY, POS_W'($urandom), POS_W'($urandom), q);
   endtask

   // A point near a cluster centre; with 1024 units per cell this stays within a few cells.
   function automatic logic signed [POS_W-1:0] near(input int centre, input int spread);
      return POS_W'(centre + $urandom_range(0, 2 * spread) - spread);
   endfunction

   // Registers change only once every expected word is out and any clear has finished.
   task automatic set_window(input logic [DSQ_W-1:0] lo, input logic [DSQ_W-1:0] hi);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = CSR_MIN_DIST_SQ;
      csr_wr_data = lo;
      @(negedge clock);
      csr_index = CSR_MAX_DIST_SQ;
      csr_wr_data = hi;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [DSQ_W-1:0] random_bound();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return DSQ_W'($urandom_range(0, 1 << 22));
         default: return DSQ_W'({$urandom, $urandom});
      endcase
   endfunction

   // Result side: a random stall before each word, or none at all while calm.
   initial begin
      int hold;
      @(negedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 14);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall = 1'b1;
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int cx, cy, n_pts, n_q;
      logic [DSQ_W-1:0] lo, hi;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset window: empty store, unused op, extreme positions.
      query_point(0);
      send_word(OP_SPARE, POS_HI, POS_LO, 5);
      load_point(POS_HI, POS_HI);
      load_point(POS_LO, POS_LO);
      load_point(20'sd0, 20'sd0);
      load_point(20'sd300, 20'sd200);
      load_point(20'sd65535, 20'sd1024);
      query_point(0);
      query_point(2);
      query_point(3);
      query_point(1023);

      // Self match and the widest window; the low extreme and the points near the origin now see one another.
      set_window('0, '1);
      query_point(0);
      query_point(1);
      query_point(2);
      // The neighbour limit: forty points packed into one cell.
      for (int k = 0; k < 40; k++) load_point(near(20000, 400), near(20000, 400));
      query_point(10);
      query_point(44);
      send_word(OP_CLEAR, '0, '0, 0);
      query_point(0);

      // Points spread over the unit square back to back, then queries under a mid window.
      calm = 1'b1;
      for (int k = 0; k < 60; k++) load_point(POS_W'($urandom_range(0, 65535)),
                                               POS_W'($urandom_range(0, 65535)));
      calm = 1'b0;
      set_window(DSQ_W'(1), DSQ_W'(1 << 21));
      for (int k = 0; k < 24; k++) query_point($urandom_range(0, 63));
      query_point(1023);

      // Random rounds: clear, a small cluster of loads, then queries, some off the end.
      while (words_sent < 370) begin
         if ($urandom_range(0, 2) == 0) begin
            lo = random_bound();
            hi = random_bound();
            if ($urandom_range(0, 1)) lo = DSQ_W'($urandom_range(0, 3));
            if ($urandom_range(0, 1)) hi = DSQ_W'($urandom_range(1 << 18, 1 << 24));
            set_window(lo, hi);
         end
         calm = ($urandom_range(0, 3) == 0);
         send_word(OP_CLEAR, '0, '0, 0);
         cx = $urandom_range(0, 70000);
         cy = $urandom_range(0, 70000);
         n_pts = $urandom_range(1, 40);
         for (int k = 0; k < n_pts; k++) begin
            case ($urandom_range(0, 9))
               0: load_point(POS_W'($urandom), POS_W'($urandom));
               1: send_word(OP_SPARE, POS_W'($urandom), POS_W'($urandom),
                            $urandom_range(0, 1023));
               default: load_point(near(cx, 3000), near(cy, 3000));
            endcase
         end
         n_q = $urandom_range(2, 8);
         for (int k = 0; k < n_q; k++) begin
            if ($urandom_range(0, 7) == 0) query_point($urandom_range(0, 1023));
            else query_point($urandom_range(0, n_pts + 1));
         end
      end

      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      $display("covered %0d request words and %0d result words,", words_sent, words_checked);
      $display("including the neighbour limit, unstored indices and both window extremes");
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #200ms;
      $display("status: fail");
      $finish;
   end
endmodule
